/* sv/mahsp_pkg.sv */
// Package for the MPEG audio header sync parser.
// Holds field widths, header codes, bitrate and sample-rate tables.
// No dependencies.
`default_nettype none

package mahsp_pkg;

   // Field and datapath widths
   localparam int BYTE_W    = 8;
   localparam int BR_W      = 9;
   localparam int FREQ_W    = 16;
   localparam int KMUL_W    = 18;
   localparam int NUM_W     = KMUL_W + BR_W;
   localparam int QUOT_W    = 11;
   localparam int DVS_W     = FREQ_W + QUOT_W - 1;
   localparam int CNT_W     = $clog2(QUOT_W);
   localparam int SIZE_W    = 12;
   localparam int SIDE_W    = 6;
   localparam int SUM_W     = SIZE_W + 1;

   // Sync pattern
   localparam logic [7:0] SYNC_BYTE   = 8'hFF;
   localparam logic [3:0] SYNC_NIBBLE = 4'hF;

   // Layer bit codes as they stand in the header
   localparam logic [1:0] LAYER_BITS_RSVD = 2'b00;
   localparam logic [1:0] LAYER_BITS_L3   = 2'b01;
   localparam logic [1:0] LAYER_BITS_L1   = 2'b11;

   // Reserved indexes
   localparam logic [3:0] BRI_BAD = 4'hF;
   localparam logic [1:0] SRI_BAD = 2'b11;
   localparam logic [1:0] CH_MODE_SINGLE = 2'b11;

   // Frame size numerator constants
   localparam logic [KMUL_W-1:0] K_LAYER1  = KMUL_W'(12000);
   localparam logic [KMUL_W-1:0] K_L3_V2   = KMUL_W'(72000);
   localparam logic [KMUL_W-1:0] K_DEFAULT = KMUL_W'(144000);

   // Side info sizes
   localparam logic [SIDE_W-1:0] SIDE_NONE  = SIDE_W'(0);
   localparam logic [SIDE_W-1:0] SIDE_SMALL = SIDE_W'(9);
   localparam logic [SIDE_W-1:0] SIDE_MID   = SIDE_W'(17);
   localparam logic [SIDE_W-1:0] SIDE_LARGE = SIDE_W'(32);

   // Bitrate tables, row by layer bits (row 0 reserved), column by bitrate index
   localparam logic [BR_W-1:0] RATE_V1 [0:3][0:15] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0}
   };

   localparam logic [BR_W-1:0] RATE_V2 [0:3][0:15] = '{
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
      '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0}
   };

   localparam logic [FREQ_W-1:0] BASE_FREQ [0:3] = '{
      FREQ_W'(44100), FREQ_W'(48000), FREQ_W'(32000), FREQ_W'(0)
   };

   // Look up the bitrate in kbit/s
   function automatic logic [BR_W-1:0] bitrate_lookup(
      input logic       v2,
      input logic [1:0] layer_bits,
      input logic [3:0] bri
   );
      logic [BR_W-1:0] rate;
      if (v2) begin
         rate = RATE_V2[layer_bits][bri];
      end else begin
         rate = RATE_V1[layer_bits][bri];
      end
      return rate;
   endfunction

   // Look up the sample rate, halved for version two
   function automatic logic [FREQ_W-1:0] freq_lookup(
      input logic       v2,
      input logic [1:0] sri
   );
      logic [FREQ_W-1:0] freq;
      freq = BASE_FREQ[sri];
      if (v2) begin
         freq = freq >> 1;
      end
      return freq;
   endfunction

endpackage

`default_nettype wire

/* sv/mahsp_div.sv */
// Iterative restoring divider for the frame size, one quotient bit per cycle.
// Depends on mahsp_pkg for widths.
`default_nettype none

module mahsp_div
   import mahsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [NUM_W-1:0]  numer,
   input  wire logic [FREQ_W-1:0] denom,
   output logic                   done,
   output logic [QUOT_W-1:0]      quot
);

   logic [NUM_W-1:0]  rem_ff,  rem_in;
   logic [DVS_W-1:0]  dvs_ff,  dvs_in;
   logic [QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]  cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic              fits;
   logic [NUM_W-1:0]  diff;

   // Trial subtract of the shifted divisor
   assign fits = rem_ff >= NUM_W'(dvs_ff);
   assign diff = rem_ff - NUM_W'(dvs_ff);

   // Load, then step one quotient bit a cycle
   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer;
         dvs_in  = {denom, (QUOT_W-1)'(0)};
         quot_in = '0;
         cnt_in  = CNT_W'(QUOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = diff;
         end
         quot_in = {quot_ff[QUOT_W-2:0], fits};
         dvs_in  = dvs_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

/* sv/mpeg_audio_header_sync_parser.sv */
// MPEG audio header sync parser: top level.
// Uses mahsp_pkg and the iterative divider mahsp_div.
//
// Usage:
//   Stream bytes enter on the req_ channel (req_valid/req_stall/req_data_byte),
//   one byte per accepted item. Each four-byte window that holds a valid MPEG
//   audio header yields one item on the rsp_ channel with the decoded header
//   fields, the table bitrate and sample rate, the side info size and the
//   signed payload size. After a header the window empties, and two CRC bytes
//   are dropped when the header announces a CRC.
// Timing:
//   A byte that completes no header is taken without a stall. A byte that
//   completes a header holds req_stall high while the sequencer runs: the size
//   multiply, the divider load, 11 quotient steps of the shared divider, and
//   the finish state, which loads the output register once it is free. The
//   result appears in the output register right after that.
// Reset and stall:
//   Synchronous active-high reset empties the window, clears the CRC skip
//   count and the output valid. While rsp_stall holds the result, new
//   bytes are still taken; a further header waits at the end of its division
//   until the output register is free.
`default_nettype none

module mpeg_audio_header_sync_parser
   import mahsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [BYTE_W-1:0] req_data_byte,

   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_is_version_two,
   output logic [1:0]             rsp_layer_number,
   output logic                   rsp_crc_present,
   output logic [BR_W-1:0]        rsp_bitrate_kbps,
   output logic [FREQ_W-1:0]      rsp_sample_rate_hz,
   output logic                   rsp_padded,
   output logic [1:0]             rsp_channel_mode,
   output logic [1:0]             rsp_mode_extension,
   output logic [2:0]             rsp_flag_bits,
   output logic [1:0]             rsp_emphasis,
   output logic signed [SIZE_W-1:0] rsp_payload_bytes,
   output logic [SIDE_W-1:0]      rsp_side_info_bytes
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_LOAD = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [23:0]       window_ff, window_in;
   logic [1:0]        fill_ff,   fill_in;
   logic [1:0]        skip_ff,   skip_in;

   logic [23:0]       hdr_ff,    hdr_in;
   logic [BR_W-1:0]   br_ff,     br_in;
   logic [FREQ_W-1:0] freq_ff,   freq_in;
   logic [NUM_W-1:0]  prod_ff,   prod_in;

   logic              req_accept;
   logic              hdr_ok;
   logic [7:0]        w_b0, w_b1, w_b2;
   logic [7:0]        h_b1, h_b2, h_b3;
   logic              h_v2;
   logic [1:0]        h_lbits;
   logic [KMUL_W-1:0] kmul;

   logic              div_start;
   logic              div_done;
   logic [QUOT_W-1:0] div_quot;

   logic              out_free;
   logic              rsp_load;
   logic [SUM_W-1:0]  size_base;
   logic [SUM_W-1:0]  size_deduct;
   logic [SUM_W-1:0]  size_sum;
   logic [SIDE_W-1:0] side_w;

   logic                     rsp_valid_ff;
   logic                     v2_ff;
   logic [1:0]               layer_ff;
   logic                     crc_ff;
   logic [BR_W-1:0]          rbr_ff;
   logic [FREQ_W-1:0]        rfreq_ff;
   logic                     pad_ff;
   logic [1:0]               mode_ff;
   logic [1:0]               modeext_ff;
   logic [2:0]               flags_ff;
   logic [1:0]               emph_ff;
   logic [SIZE_W-1:0]        size_ff;
   logic [SIDE_W-1:0]        side_ff;

   // Window bytes, oldest first
   assign w_b0 = window_ff[23:16];
   assign w_b1 = window_ff[15:8];
   assign w_b2 = window_ff[7:0];

   // Header check on the held three bytes
   assign hdr_ok = (w_b0 == SYNC_BYTE) && (w_b1[7:4] == SYNC_NIBBLE)
                && (w_b1[2:1] != LAYER_BITS_RSVD) && (w_b2[7:4] != BRI_BAD)
                && (w_b2[3:2] != SRI_BAD);

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Latched header bytes
   assign h_b1    = hdr_ff[23:16];
   assign h_b2    = hdr_ff[15:8];
   assign h_b3    = hdr_ff[7:0];
   assign h_v2    = ~h_b1[3];
   assign h_lbits = h_b1[2:1];

   // Select the frame size constant
   always_comb begin
      if (h_lbits == LAYER_BITS_L1) begin
         kmul = K_LAYER1;
      end else if (h_lbits == LAYER_BITS_L3 && h_v2) begin
         kmul = K_L3_V2;
      end else begin
         kmul = K_DEFAULT;
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_load = (state_ff == ST_FIN) && out_free;
   assign div_start = (state_ff == ST_LOAD);

   // Sequencer and byte window
   always_comb begin
      state_in  = state_ff;
      window_in = window_ff;
      fill_in   = fill_ff;
      skip_in   = skip_ff;
      hdr_in    = hdr_ff;
      br_in     = br_ff;
      freq_in   = freq_ff;
      prod_in   = prod_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (skip_ff != 2'd0) begin
                  skip_in = skip_ff - 2'd1;
               end else if (fill_ff != 2'd3) begin
                  window_in = {window_ff[15:0], req_data_byte};
                  fill_in   = fill_ff + 2'd1;
               end else if (!hdr_ok) begin
                  window_in = {window_ff[15:0], req_data_byte};
               end else begin
                  hdr_in    = {w_b1, w_b2, req_data_byte};
                  br_in     = bitrate_lookup(~w_b1[3], w_b1[2:1], w_b2[7:4]);
                  freq_in   = freq_lookup(~w_b1[3], w_b2[3:2]);
                  window_in = '0;
                  fill_in   = 2'd0;
                  skip_in   = w_b1[0] ? 2'd0 : 2'd2;
                  state_in  = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = NUM_W'(kmul) * NUM_W'(br_ff);
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         window_ff <= '0;
         fill_ff   <= 2'd0;
         skip_ff   <= 2'd0;
      end else begin
         state_ff  <= state_in;
         window_ff <= window_in;
         fill_ff   <= fill_in;
         skip_ff   <= skip_in;
      end
      hdr_ff  <= hdr_in;
      br_ff   <= br_in;
      freq_ff <= freq_in;
      prod_ff <= prod_in;
   end

   // Shared divider: product over sample rate
   mahsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (prod_ff),
      .denom (freq_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Side info size for layer 3
   always_comb begin
      if (h_lbits != LAYER_BITS_L3) begin
         side_w = SIDE_NONE;
      end else if (h_v2) begin
         side_w = (h_b3[7:6] == CH_MODE_SINGLE) ? SIDE_SMALL : SIDE_MID;
      end else begin
         side_w = (h_b3[7:6] == CH_MODE_SINGLE) ? SIDE_MID : SIDE_LARGE;
      end
   end

   // Frame size less header, side info and CRC
   always_comb begin
      if (h_lbits == LAYER_BITS_L1) begin
         size_base = SUM_W'({div_quot, 2'b00})
                   + SUM_W'({h_b2[1], 2'b00});
      end else begin
         size_base = SUM_W'(div_quot) + SUM_W'(h_b2[1]);
      end
      size_deduct = SUM_W'(4) + SUM_W'(side_w) + SUM_W'({~h_b1[0], 1'b0});
      size_sum    = size_base - size_deduct;
   end

   // Output register: hold until taken, load when free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         v2_ff      <= h_v2;
         layer_ff   <= 2'(3'd4 - {1'b0, h_lbits});
         crc_ff     <= ~h_b1[0];
         rbr_ff     <= br_ff;
         rfreq_ff   <= freq_ff;
         pad_ff     <= h_b2[1];
         mode_ff    <= h_b3[7:6];
         modeext_ff <= h_b3[5:4];
         flags_ff   <= {h_b2[0], h_b3[3:2]};
         emph_ff    <= h_b3[1:0];
         size_ff    <= size_sum[SIZE_W-1:0];
         side_ff    <= side_w;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_is_version_two  = v2_ff;
   assign rsp_layer_number    = layer_ff;
   assign rsp_crc_present     = crc_ff;
   assign rsp_bitrate_kbps    = rbr_ff;
   assign rsp_sample_rate_hz  = rfreq_ff;
   assign rsp_padded          = pad_ff;
   assign rsp_channel_mode    = mode_ff;
   assign rsp_mode_extension  = modeext_ff;
   assign rsp_flag_bits       = flags_ff;
   assign rsp_emphasis        = emph_ff;
   assign rsp_payload_bytes   = $signed(size_ff);
   assign rsp_side_info_bytes = side_ff;

endmodule

`default_nettype wire
